### src/qau_pkg.sv
`timescale 1ns / 1ps

package qau_pkg;

   localparam int COMP_WIDTH    = 16;
   localparam int FRAC_BITS     = 12;
   localparam int ACT_WIDTH     = 3;
   localparam int LANES         = 4;

   localparam int PROD_WIDTH    = 2 * COMP_WIDTH + 1;
   localparam int ACC_WIDTH     = PROD_WIDTH + 2;
   localparam int SQ_WIDTH      = 2 * COMP_WIDTH - 1;
   localparam int SUM_WIDTH     = SQ_WIDTH + 2;
   localparam int SQRT_WIDTH    = SUM_WIDTH + 1;
   localparam int SQRT_STAGES   = COMP_WIDTH + 1;
   localparam int MAG_WIDTH     = COMP_WIDTH + 1;
   localparam int DIV_NUM_WIDTH = COMP_WIDTH + FRAC_BITS;
   localparam int DIV_STAGES    = DIV_NUM_WIDTH;
   localparam int REM_WIDTH     = MAG_WIDTH + 1;

   localparam int LANE_LAT      = 1;
   localparam int MAG_DELAY     = SQRT_STAGES + 2;
   localparam int ARITH_DELAY   = MAG_DELAY + DIV_STAGES;
   localparam int PIPE_DEPTH    = LANE_LAT + ARITH_DELAY;

   localparam int COMP_MAX      = 2 ** (COMP_WIDTH - 1) - 1;
   localparam int UCOMP_MAX     = 2 ** COMP_WIDTH - 1;

   typedef enum logic [ACT_WIDTH-1:0] {
      ACT_ADD,
      ACT_MUL,
      ACT_SCALE,
      ACT_CONJ,
      ACT_NORM
   } action_type;

   typedef logic signed [COMP_WIDTH-1:0] comp_type;

   typedef struct packed {
      logic [ACT_WIDTH-1:0] action;
      comp_type             a_w;
      comp_type             a_x;
      comp_type             a_y;
      comp_type             a_z;
      comp_type             b_w;
      comp_type             b_x;
      comp_type             b_y;
      comp_type             b_z;
      comp_type             scale_factor;
   } req_item_type;

   typedef struct packed {
      comp_type              r_w;
      comp_type              r_x;
      comp_type              r_y;
      comp_type              r_z;
      logic [COMP_WIDTH-1:0] norm_value;
      logic                  overflow_flag;
      logic                  zero_norm_flag;
   } rsp_item_type;

   typedef struct packed {
      comp_type val;
      logic     ovf;
   } sat_type;

   typedef struct packed {
      sat_type                  arith;
      logic                     neg;
      logic [DIV_NUM_WIDTH-1:0] quo;
   } lane_out_type;

   localparam logic [1:0] HAM_B_IDX [LANES][LANES] = '{
      '{2'd0, 2'd1, 2'd2, 2'd3},
      '{2'd1, 2'd0, 2'd3, 2'd2},
      '{2'd2, 2'd3, 2'd0, 2'd1},
      '{2'd3, 2'd2, 2'd1, 2'd0}
   };

   localparam logic [LANES-1:0] HAM_NEG [LANES] = '{
      4'b1110,
      4'b1000,
      4'b0010,
      4'b0100
   };

   function automatic sat_type saturate(input logic signed [ACC_WIDTH-1:0] v);
      sat_type                     r;
      logic signed [ACC_WIDTH-1:0] hi;
      logic signed [ACC_WIDTH-1:0] lo;
      hi = $signed(ACC_WIDTH'(COMP_MAX));
      lo = -hi - $signed(ACC_WIDTH'(1));
      if (v > hi) begin
         r.val = hi[COMP_WIDTH-1:0];
         r.ovf = 1'b1;
      end else if (v < lo) begin
         r.val = lo[COMP_WIDTH-1:0];
         r.ovf = 1'b1;
      end else begin
         r.val = v[COMP_WIDTH-1:0];
         r.ovf = 1'b0;
      end
      return r;
   endfunction

endpackage

### src/qau_sqrt.sv
`timescale 1ns / 1ps

module qau_sqrt
   import qau_pkg::*;
(
   input  logic                 clock,
   input  logic                 adv,
   input  logic [SUM_WIDTH-1:0] sum,
   output logic [MAG_WIDTH-1:0] mag
);

   logic [SQRT_WIDTH-1:0] s_ff [SQRT_STAGES];
   logic [SQRT_WIDTH-1:0] s_in [SQRT_STAGES];
   logic [SQRT_WIDTH-1:0] r_ff [SQRT_STAGES];
   logic [SQRT_WIDTH-1:0] r_in [SQRT_STAGES];
   logic [MAG_WIDTH-1:0]  m_ff;
   logic [MAG_WIDTH-1:0]  m_in;
   logic [SQRT_WIDTH-1:0] rem;
   logic [SQRT_WIDTH-1:0] root;

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      localparam logic [SQRT_WIDTH-1:0] BIT = SQRT_WIDTH'(1) << (2 * (SQRT_STAGES - 1 - k));
      logic [SQRT_WIDTH-1:0] s_prev;
      logic [SQRT_WIDTH-1:0] r_prev;
      logic [SQRT_WIDTH-1:0] t;
      if (k == 0) begin : g_first
         assign s_prev = SQRT_WIDTH'(sum);
         assign r_prev = '0;
      end else begin : g_next
         assign s_prev = s_ff[k-1];
         assign r_prev = r_ff[k-1];
      end
      always_comb begin
         t = r_prev + BIT;
         if (s_prev >= t) begin
            s_in[k] = s_prev - t;
            r_in[k] = (r_prev >> 1) + BIT;
         end else begin
            s_in[k] = s_prev;
            r_in[k] = r_prev >> 1;
         end
      end
   end

   always_comb begin
      rem  = s_ff[SQRT_STAGES-1];
      root = r_ff[SQRT_STAGES-1];
      m_in = MAG_WIDTH'(root) + MAG_WIDTH'(rem > root);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff <= s_in;
         r_ff <= r_in;
         m_ff <= m_in;
      end
   end

   assign mag = m_ff;

endmodule

### src/qau_div.sv
`timescale 1ns / 1ps

module qau_div
   import qau_pkg::*;
(
   input  logic                     clock,
   input  logic                     adv,
   input  logic [DIV_NUM_WIDTH-1:0] num,
   input  logic [MAG_WIDTH-1:0]     den,
   output logic [DIV_NUM_WIDTH-1:0] quo
);

   logic [MAG_WIDTH-1:0]     rem_ff [DIV_STAGES];
   logic [MAG_WIDTH-1:0]     rem_in [DIV_STAGES];
   logic [DIV_NUM_WIDTH-1:0] num_ff [DIV_STAGES];
   logic [DIV_NUM_WIDTH-1:0] num_in [DIV_STAGES];
   logic [DIV_NUM_WIDTH-1:0] quo_ff [DIV_STAGES];
   logic [DIV_NUM_WIDTH-1:0] quo_in [DIV_STAGES];
   logic [MAG_WIDTH-1:0]     den_ff [DIV_STAGES];
   logic [MAG_WIDTH-1:0]     den_in [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [MAG_WIDTH-1:0]     rem_prev;
      logic [DIV_NUM_WIDTH-1:0] num_prev;
      logic [DIV_NUM_WIDTH-1:0] quo_prev;
      logic [MAG_WIDTH-1:0]     den_prev;
      logic [REM_WIDTH-1:0]     x;
      logic [REM_WIDTH-1:0]     d;
      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign num_prev = num;
         assign quo_prev = '0;
         assign den_prev = den;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign num_prev = num_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign den_prev = den_ff[k-1];
      end
      always_comb begin
         x         = {rem_prev, num_prev[DIV_NUM_WIDTH-1]};
         d         = {1'b0, den_prev};
         num_in[k] = num_prev << 1;
         den_in[k] = den_prev;
         if (x >= d) begin
            rem_in[k] = MAG_WIDTH'(x - d);
            quo_in[k] = {quo_prev[DIV_NUM_WIDTH-2:0], 1'b1};
         end else begin
            rem_in[k] = MAG_WIDTH'(x);
            quo_in[k] = {quo_prev[DIV_NUM_WIDTH-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
         quo_ff <= quo_in;
         den_ff <= den_in;
      end
   end

   assign quo = quo_ff[DIV_STAGES-1];

endmodule

### src/qau_lane.sv
`timescale 1ns / 1ps

module qau_lane
   import qau_pkg::*;
(
   input  logic                 clock,
   input  logic                 adv,
   input  logic [ACT_WIDTH-1:0] action,
   input  comp_type             a_vec [LANES],
   input  comp_type             b_perm [LANES],
   input  logic [LANES-1:0]     neg_mask,
   input  comp_type             own_a,
   input  comp_type             own_b,
   input  comp_type             scale,
   input  logic                 conj_neg,
   input  logic [MAG_WIDTH-1:0] mag,
   output logic [SQ_WIDTH-1:0]  sq,
   output lane_out_type         lane_out
);

   typedef struct packed {
      sat_type arith;
      logic    neg;
   } carry_type;

   logic signed [PROD_WIDTH-1:0]   prod_ff [LANES];
   logic signed [PROD_WIDTH-1:0]   prod_in [LANES];
   logic signed [2*COMP_WIDTH-1:0] scl_ff;
   logic signed [2*COMP_WIDTH-1:0] scl_in;
   logic [SQ_WIDTH-1:0]            sq_ff;
   logic [SQ_WIDTH-1:0]            sq_in;
   logic [ACT_WIDTH-1:0]           act_ff;
   comp_type                       own_a_ff;
   comp_type                       own_b_ff;
   logic signed [2*COMP_WIDTH-1:0] p [LANES];
   logic signed [2*COMP_WIDTH-1:0] p_sq;

   logic signed [ACC_WIDTH-1:0]    acc;
   logic signed [ACC_WIDTH-1:0]    sel;
   carry_type                      carry_line_ff [ARITH_DELAY];
   carry_type                      carry_line_in [ARITH_DELAY];
   logic [COMP_WIDTH-1:0]          mag_line_ff [MAG_DELAY];
   logic [COMP_WIDTH-1:0]          mag_line_in [MAG_DELAY];
   logic [DIV_NUM_WIDTH-1:0]       num;
   logic [DIV_NUM_WIDTH-1:0]       quo;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         p[i]       = a_vec[i] * b_perm[i];
         prod_in[i] = neg_mask[i] ? -PROD_WIDTH'(p[i]) : PROD_WIDTH'(p[i]);
      end
      scl_in = own_a * scale;
      p_sq   = own_a * own_a;
      sq_in  = SQ_WIDTH'($unsigned(p_sq));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff  <= prod_in;
         scl_ff   <= scl_in;
         sq_ff    <= sq_in;
         act_ff   <= action;
         own_a_ff <= own_a;
         own_b_ff <= own_b;
      end
   end

   assign sq = sq_ff;

   always_comb begin
      acc = $signed(ACC_WIDTH'(1)) <<< (FRAC_BITS - 1);
      for (int i = 0; i < LANES; i++) begin
         acc = acc + ACC_WIDTH'(prod_ff[i]);
      end
      case (act_ff)
         ACT_ADD:   sel = ACC_WIDTH'(own_a_ff) + ACC_WIDTH'(own_b_ff);
         ACT_MUL:   sel = acc >>> FRAC_BITS;
         ACT_SCALE: sel = (ACC_WIDTH'(scl_ff) + ($signed(ACC_WIDTH'(1)) <<< (FRAC_BITS - 1)))
                          >>> FRAC_BITS;
         ACT_CONJ:  sel = conj_neg ? -ACC_WIDTH'(own_a_ff) : ACC_WIDTH'(own_a_ff);
         default:   sel = '0;
      endcase
      carry_line_in[0].arith = saturate(sel);
      carry_line_in[0].neg   = own_a_ff[COMP_WIDTH-1];
      for (int i = 1; i < ARITH_DELAY; i++) begin
         carry_line_in[i] = carry_line_ff[i-1];
      end
      mag_line_in[0] = own_a_ff[COMP_WIDTH-1] ? COMP_WIDTH'(-own_a_ff) : COMP_WIDTH'(own_a_ff);
      for (int i = 1; i < MAG_DELAY; i++) begin
         mag_line_in[i] = mag_line_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         carry_line_ff <= carry_line_in;
         mag_line_ff   <= mag_line_in;
      end
   end

   assign num = (DIV_NUM_WIDTH'(mag_line_ff[MAG_DELAY-1]) << FRAC_BITS)
              + DIV_NUM_WIDTH'(mag >> 1);

   qau_div u_div (
      .clock (clock),
      .adv   (adv),
      .num   (num),
      .den   (mag),
      .quo   (quo)
   );

   always_comb begin
      lane_out.arith = carry_line_ff[ARITH_DELAY-1].arith;
      lane_out.neg   = carry_line_ff[ARITH_DELAY-1].neg;
      lane_out.quo   = quo;
   end

endmodule

### src/quaternion_arithmetic_unit.sv
`timescale 1ns / 1ps

// channel  direction  payload        handshake
// req      in         req_item_type  req_valid / req_stall
// rsp      out        rsp_item_type  rsp_valid / rsp_stall
//
// One transaction per cycle sustained while the output is not stalled; the response
// path runs through the 17-stage square root and 28-stage divider lanes.
// Reset clears the valid bits of every stage and the input skid register.
// A stalled output freezes the whole pipeline; a one-entry skid register
// takes one more transaction before req_stall rises.

module quaternion_arithmetic_unit
   import qau_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   logic                 adv;
   logic                 accept;
   logic                 skid_full_ff;
   logic                 skid_full_in;
   req_item_type         skid_ff;
   req_item_type         skid_in;
   logic                 in_valid_ff;
   logic                 in_valid_in;
   req_item_type         in_item_ff;
   req_item_type         in_item_in;
   logic                 v_line_ff [PIPE_DEPTH];
   logic                 v_line_in [PIPE_DEPTH];
   logic [ACT_WIDTH-1:0] act_line_ff [PIPE_DEPTH];
   logic [ACT_WIDTH-1:0] act_line_in [PIPE_DEPTH];
   logic [MAG_WIDTH-1:0] m_line_ff [DIV_STAGES];
   logic [MAG_WIDTH-1:0] m_line_in [DIV_STAGES];
   logic [SUM_WIDTH-1:0] sumsq_ff;
   logic [SUM_WIDTH-1:0] sumsq_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_item_type         rsp_item_ff;
   rsp_item_type         rsp_item_in;

   comp_type             a_vec [LANES];
   comp_type             b_vec [LANES];
   logic [SQ_WIDTH-1:0]  sq [LANES];
   lane_out_type         lane_out [LANES];
   logic [MAG_WIDTH-1:0] mag;

   logic [MAG_WIDTH-1:0] m_end;
   comp_type             res [LANES];
   logic                 ovf;
   sat_type              nsat;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && !skid_full_ff;
   assign req_stall = skid_full_ff;

   always_comb begin
      skid_full_in = skid_full_ff;
      skid_in      = skid_ff;
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      if (adv) begin
         skid_full_in = 1'b0;
         in_valid_in  = skid_full_ff || accept;
         in_item_in   = skid_full_ff ? skid_ff : req_data;
      end else if (accept) begin
         skid_full_in = 1'b1;
         skid_in      = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
         in_valid_ff  <= 1'b0;
      end else begin
         skid_full_ff <= skid_full_in;
         in_valid_ff  <= in_valid_in;
      end
      skid_ff    <= skid_in;
      in_item_ff <= in_item_in;
   end

   assign a_vec = '{in_item_ff.a_w, in_item_ff.a_x, in_item_ff.a_y, in_item_ff.a_z};
   assign b_vec = '{in_item_ff.b_w, in_item_ff.b_x, in_item_ff.b_y, in_item_ff.b_z};

   for (genvar j = 0; j < LANES; j++) begin : g_lane
      comp_type b_perm [LANES];
      for (genvar i = 0; i < LANES; i++) begin : g_perm
         assign b_perm[i] = b_vec[HAM_B_IDX[j][i]];
      end
      qau_lane u_lane (
         .clock    (clock),
         .adv      (adv),
         .action   (in_item_ff.action),
         .a_vec    (a_vec),
         .b_perm   (b_perm),
         .neg_mask (HAM_NEG[j]),
         .own_a    (a_vec[j]),
         .own_b    (b_vec[j]),
         .scale    (in_item_ff.scale_factor),
         .conj_neg (j != 0),
         .mag      (mag),
         .sq       (sq[j]),
         .lane_out (lane_out[j])
      );
   end

   always_comb begin
      sumsq_in = '0;
      for (int j = 0; j < LANES; j++) begin
         sumsq_in = sumsq_in + SUM_WIDTH'(sq[j]);
      end
   end

   qau_sqrt u_sqrt (
      .clock (clock),
      .adv   (adv),
      .sum   (sumsq_ff),
      .mag   (mag)
   );

   always_comb begin
      v_line_in[0]   = in_valid_ff;
      act_line_in[0] = in_item_ff.action;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
         v_line_in[i]   = v_line_ff[i-1];
         act_line_in[i] = act_line_ff[i-1];
      end
      m_line_in[0] = mag;
      for (int i = 1; i < DIV_STAGES; i++) begin
         m_line_in[i] = m_line_ff[i-1];
      end
   end

   always_comb begin
      m_end = m_line_ff[DIV_STAGES-1];
      ovf   = 1'b0;
      nsat  = '0;
      for (int j = 0; j < LANES; j++) begin
         if (act_line_ff[PIPE_DEPTH-1] == ACT_NORM) begin
            if (m_end == '0) begin
               res[j] = '0;
            end else begin
               nsat = saturate(lane_out[j].neg
                              ? -$signed({{(ACC_WIDTH-DIV_NUM_WIDTH){1'b0}}, lane_out[j].quo})
                              : $signed({{(ACC_WIDTH-DIV_NUM_WIDTH){1'b0}}, lane_out[j].quo}));
               res[j] = nsat.val;
               ovf    = ovf | nsat.ovf;
            end
         end else begin
            res[j] = lane_out[j].arith.val;
            ovf    = ovf | lane_out[j].arith.ovf;
         end
      end
      rsp_valid_in               = v_line_ff[PIPE_DEPTH-1];
      rsp_item_in.r_w            = res[0];
      rsp_item_in.r_x            = res[1];
      rsp_item_in.r_y            = res[2];
      rsp_item_in.r_z            = res[3];
      rsp_item_in.norm_value     = (m_end > MAG_WIDTH'(UCOMP_MAX)) ? COMP_WIDTH'(UCOMP_MAX)
                                                                   : m_end[COMP_WIDTH-1:0];
      rsp_item_in.overflow_flag  = ovf;
      rsp_item_in.zero_norm_flag = (act_line_ff[PIPE_DEPTH-1] == ACT_NORM) && (m_end == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_DEPTH; i++) begin
            v_line_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v_line_ff    <= v_line_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (adv) begin
         act_line_ff <= act_line_in;
         m_line_ff   <= m_line_in;
         sumsq_ff    <= sumsq_in;
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_item_ff;

`ifndef SYNTHESIS
   a_skid_only_when_stalled: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_full_ff) |-> $past(!adv))
      else $error("skid register filled while pipeline advanced");

   a_zero_norm_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.zero_norm_flag |->
         rsp_item_ff.r_w == '0 && rsp_item_ff.r_x == '0 &&
         rsp_item_ff.r_y == '0 && rsp_item_ff.r_z == '0 &&
         rsp_item_ff.norm_value == '0 && !rsp_item_ff.overflow_flag)
      else $error("zero magnitude result is not cleared");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff && adv |=> !skid_full_ff && in_valid_ff)
      else $error("skid register did not drain into the pipeline");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import qau_pkg::*;

   localparam int LATENCY   = 49;
   localparam int WDOG_MAX  = 4000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_data;

   rsp_item_type expected_rsps[$];
   int           mismatches;
   int           sent_count;
   int           rsp_count;
   int           send_idle_pct;
   int           recv_idle_pct;
   logic         hold_off;
   int           wdog;

   quaternion_arithmetic_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint unsigned int_sqrt(longint unsigned s);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint clamp16(longint v, ref logic ovf);
      if (v > 32767) begin
         ovf = 1'b1;
         return 32767;
      end
      if (v < -32768) begin
         ovf = 1'b1;
         return -32768;
      end
      return v;
   endfunction

   // round to nearest, ties up
   function automatic longint round_q12(longint v);
      return (v + 2048) >>> 12;
   endfunction

   function automatic rsp_item_type quat_result(req_item_type q);
      rsp_item_type    r;
      longint          a[4];
      longint          b[4];
      longint          res[4];
      longint          s;
      longint unsigned sq;
      longint unsigned m;
      longint unsigned mg;
      longint unsigned quo;
      logic            ovf;
      a = '{q.a_w, q.a_x, q.a_y, q.a_z};
      b = '{q.b_w, q.b_x, q.b_y, q.b_z};
      s = q.scale_factor;
      res = '{0, 0, 0, 0};
      ovf = 1'b0;
      r = '0;
      sq = 0;
      for (int i = 0; i < 4; i++) sq += a[i] * a[i];
      m = int_sqrt(sq);
      if (sq - m * m > m) m++;
      case (q.action)
         ACT_ADD: for (int i = 0; i < 4; i++) res[i] = clamp16(a[i] + b[i], ovf);
         ACT_MUL: begin
            res[0] = clamp16(round_q12(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]), ovf);
            res[1] = clamp16(round_q12(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2]), ovf);
            res[2] = clamp16(round_q12(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1]), ovf);
            res[3] = clamp16(round_q12(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0]), ovf);
         end
         ACT_SCALE: for (int i = 0; i < 4; i++) res[i] = clamp16(round_q12(a[i] * s), ovf);
         ACT_CONJ: begin
            res[0] = a[0];
            for (int i = 1; i < 4; i++) res[i] = clamp16(-a[i], ovf);
         end
         ACT_NORM: begin
            if (m == 0) begin
               r.zero_norm_flag = 1'b1;
            end else begin
               for (int i = 0; i < 4; i++) begin
                  mg = (a[i] < 0) ? -a[i] : a[i];
                  quo = ((mg << 12) + (m >> 1)) / m;
                  res[i] = clamp16((a[i] < 0) ? -longint'(quo) : longint'(quo), ovf);
               end
            end
         end
         default: ;
      endcase
      r.r_w = res[0][15:0];
      r.r_x = res[1][15:0];
      r.r_y = res[2][15:0];
      r.r_z = res[3][15:0];
      r.norm_value = (m > 65535) ? 16'hFFFF : m[15:0];
      r.overflow_flag = ovf;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      mismatches++;
   endtask

   task automatic send_quat(req_item_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      expected_rsps.push_back(quat_result(q));
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         rsp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected transaction", 1, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.r_w != want.r_w) report_mismatch("r_w", rsp_data.r_w, want.r_w);
            if (rsp_data.r_x != want.r_x) report_mismatch("r_x", rsp_data.r_x, want.r_x);
            if (rsp_data.r_y != want.r_y) report_mismatch("r_y", rsp_data.r_y, want.r_y);
            if (rsp_data.r_z != want.r_z) report_mismatch("r_z", rsp_data.r_z, want.r_z);
            if (rsp_data.norm_value != want.norm_value)
               report_mismatch("norm_value", rsp_data.norm_value, want.norm_value);
            if (rsp_data.overflow_flag != want.overflow_flag)
               report_mismatch("overflow_flag", rsp_data.overflow_flag, want.overflow_flag);
            if (rsp_data.zero_norm_flag != want.zero_norm_flag)
               report_mismatch("zero_norm_flag", rsp_data.zero_norm_flag, want.zero_norm_flag);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         wdog <= 0;
      end else begin
         wdog <= wdog + 1;
         if (wdog >= WDOG_MAX) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   function automatic logic [15:0] rand_comp();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($signed($urandom_range(8191)) - 4096);
         3: return 16'($urandom_range(3));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_item_type rand_quat(logic [2:0] act);
      req_item_type q;
      q.action = act;
      q.a_w = rand_comp(); q.a_x = rand_comp(); q.a_y = rand_comp(); q.a_z = rand_comp();
      q.b_w = rand_comp(); q.b_x = rand_comp(); q.b_y = rand_comp(); q.b_z = rand_comp();
      q.scale_factor = rand_comp();
      return q;
   endfunction

   function automatic req_item_type fill_quat(logic [2:0] act, logic [15:0] av,
                                              logic [15:0] bv, logic [15:0] sv);
      req_item_type q;
      q = '{act, av, av, av, av, bv, bv, bv, bv, sv};
      return q;
   endfunction

   task automatic test_directed();
      req_item_type q;
      for (int act = 0; act < 8; act++) begin
         send_quat(fill_quat(3'(act), 16'h7FFF, 16'h7FFF, 16'h7FFF));
         send_quat(fill_quat(3'(act), 16'h8000, 16'h8000, 16'h8000));
      end
      send_quat(fill_quat(ACT_NORM, 16'h0000, 16'h1234, 16'h1000));
      send_quat(fill_quat(ACT_ADD, 16'h0000, 16'h0000, 16'h0000));
      send_quat(fill_quat(ACT_CONJ, 16'h8000, 16'h0000, 16'h0000));
      q = fill_quat(ACT_NORM, 16'h0000, 16'h0000, 16'h0000);
      q.a_x = 16'h0001;
      send_quat(q);
      q = fill_quat(ACT_MUL, 16'h1000, 16'h1000, 16'h1000);
      q.a_y = 16'hF000;
      send_quat(q);
      send_quat(fill_quat(ACT_SCALE, 16'h0001, 16'h0000, 16'h0800));
      send_quat(fill_quat(ACT_SCALE, 16'hFFFF, 16'h0000, 16'h0800));
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++)
         send_quat(rand_quat((i % 10 == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4))));
   endtask

   task automatic test_backpressure();
      int hold_cycles;
      hold_cycles = 150;
      fork
         begin
            hold_off = 1'b1;
            repeat (hold_cycles) @(posedge clock);
            hold_off = 1'b0;
         end
         test_random(120);
      join
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      hold_off = 1'b0;
      mismatches = 0;
      sent_count = 0;
      rsp_count = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_idle_pct = 27;
      recv_idle_pct = 60;
      test_random(380);
      send_idle_pct = 60;
      recv_idle_pct = 27;
      test_random(380);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(350);
      test_backpressure();
      drain();
      $display("covered all actions incl. undefined, saturation, zero norm, long hold-off");
      $display("transactions sent %0d, received %0d, mismatches %0d",
               sent_count, rsp_count, mismatches);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
